// File: design/hue_lightness_map_pixel_defines.svh
// Assertion macros shared by the hue-lightness map pixel design.
`ifndef HUE_LIGHTNESS_MAP_PIXEL_DEFINES_SVH
`define HUE_LIGHTNESS_MAP_PIXEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hlm_pkg.sv
// Shared constants, types and functions of the hue-lightness map pixel design.
package hlm_pkg;

  localparam int FRAC_BITS = 16;
  // Fixed-point ratios reach one, so they need one integer bit.
  localparam int QW = FRAC_BITS + 1;
  localparam int REM_W = 14;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam logic [QW-1:0] FX_ONE = QW'(1) << FRAC_BITS;

  localparam int CFG_W = 13;
  localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SAT_STEP = 2'd2;
  localparam logic [1:0] REG_SAT_LEVELS = 2'd3;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;

  // Ratios leaving the divider pipeline.
  typedef struct packed {
    logic [QW-1:0] hue;
    logic [QW-1:0] sat;
    logic [QW-1:0] lq;
    logic bad;
  } ratio_t;

  // One pixel result.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic bad;
  } pixel_t;

  // Scales a fraction to a channel value, floor(v * 255) clamped to 255.
  function automatic logic [7:0] to_channel(input logic [QW:0] v);
    logic [QW+8:0] p;
    logic [QW+8-FRAC_BITS:0] c;
    p = {v, 8'd0} - (QW+9)'(v);
    c = p[QW+8:FRAC_BITS];
    return (c > (QW+9-FRAC_BITS)'(255)) ? 8'd255 : c[7:0];
  endfunction

endpackage

// File: design/hlm_ratio.sv
// Pipelined restoring dividers for hue, saturation and lightness ratios.
module hlm_ratio (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0] step,
  input  logic bad,
  input  logic [hlm_pkg::CFG_W-1:0] div_w,
  input  logic [hlm_pkg::CFG_W-1:0] div_h,
  input  logic [hlm_pkg::CFG_W-1:0] div_l,
  output logic out_valid,
  input  logic out_ready,
  output hlm_pkg::ratio_t out_ratio
);
  import hlm_pkg::*;

  logic v [DIV_STAGES];
  logic bad_s [DIV_STAGES];
  logic [REM_W-1:0] rem [DIV_STAGES][3];
  logic [QW-1:0] quo [DIV_STAGES][3];
  logic [REM_W-1:0] rem_next [DIV_STAGES][3];
  logic [QW-1:0] quo_next [DIV_STAGES][3];
  logic [DIV_STAGES:0] rdy;
  logic [REM_W-1:0] dvs [3];
  logic [REM_W-1:0] num [3];

  assign dvs[0] = REM_W'(div_w);
  assign dvs[1] = REM_W'(div_h);
  assign dvs[2] = REM_W'(div_l);
  assign num[0] = REM_W'(col);
  assign num[1] = REM_W'(row);
  assign num[2] = REM_W'(step);

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  // One quotient bit per stage and lane; the first stage yields the integer bit.
  always_comb begin
    logic [REM_W-1:0] t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int k = 0; k < 3; k++) begin
        if (s == 0) begin
          t = num[k];
          quo_next[s][k] = QW'(t >= dvs[k]);
        end else begin
          t = {rem[s-1][k][REM_W-2:0], 1'b0};
          quo_next[s][k] = {quo[s-1][k][QW-2:0], t >= dvs[k]};
        end
        rem_next[s][k] = (t >= dvs[k]) ? t - dvs[k] : t;
      end
    end
  end

  // Valid bits move with their words; reset empties every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) begin
        bad_s[s] <= (s == 0) ? bad : bad_s[s-1];
        for (int k = 0; k < 3; k++) begin
          rem[s][k] <= rem_next[s][k];
          quo[s][k] <= quo_next[s][k];
        end
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_ratio.hue = quo[DIV_STAGES-1][0];
  assign out_ratio.lq = quo[DIV_STAGES-1][1];
  assign out_ratio.sat = quo[DIV_STAGES-1][2];
  assign out_ratio.bad = bad_s[DIV_STAGES-1];

endmodule

// File: design/hlm_color.sv
// Four-stage HSL to RGB datapath: distances, chroma, offset, channel scaling.
module hlm_color (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  hlm_pkg::ratio_t in_ratio,
  output logic out_valid,
  input  logic out_ready,
  output hlm_pkg::pixel_t out_pixel
);
  import hlm_pkg::*;

  logic [4:0] rdy;
  logic [3:0] v;

  // Stage one registers.
  logic [QW-1:0] s1_light, s1_sat, s1_omd, s1_omf;
  logic [2:0] s1_sector, s2_sector, s3_sector;
  logic s1_bad, s2_bad, s3_bad;
  // Stage two registers.
  logic [QW-1:0] s2_light, s2_omf, s2_chroma;
  // Stage three registers.
  logic [QW:0] s3_vc, s3_vx, s3_m;
  pixel_t s4_pix;

  logic [QW-1:0] light_next, omd_next, omf_next, chroma_next, x_next, m_next;
  logic [QW:0] twol;
  logic [QW+2:0] hs;
  logic [QW-1:0] fm, ldist, fdist;
  logic [2*QW-1:0] prod_c, prod_x;
  logic [7:0] vc, vx, vm;
  pixel_t pix_next;

  always_comb begin
    rdy[4] = out_ready;
    for (int s = 3; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  // Lightness, twice its distance from one half, and the hue sector split.
  always_comb begin
    light_next = FX_ONE - in_ratio.lq;
    twol = {light_next, 1'b0};
    ldist = (twol >= (QW+1)'(FX_ONE)) ? QW'(twol - (QW+1)'(FX_ONE))
                                      : QW'((QW+1)'(FX_ONE) - twol);
    omd_next = FX_ONE - ldist;
    hs = (QW+3)'(in_ratio.hue) * (QW+3)'(6);
    fm = QW'(hs[FRAC_BITS:0]);
    fdist = (fm >= FX_ONE) ? fm - FX_ONE : FX_ONE - fm;
    omf_next = FX_ONE - fdist;
  end

  // Chroma product.
  assign prod_c = (2*QW)'(s1_omd) * (2*QW)'(s1_sat);
  assign chroma_next = prod_c[FRAC_BITS+QW-1:FRAC_BITS];

  // Second component and the offset.
  assign prod_x = (2*QW)'(s2_chroma) * (2*QW)'(s2_omf);
  assign x_next = prod_x[FRAC_BITS+QW-1:FRAC_BITS];
  assign m_next = s2_light - (s2_chroma >> 1);

  // Channel scaling and the sector switch; bad pixels come out black.
  always_comb begin
    vc = to_channel(s3_vc);
    vx = to_channel(s3_vx);
    vm = to_channel(s3_m);
    unique case (s3_sector)
      SECTOR_0: pix_next = '{red: vc, green: vx, blue: vm, bad: 1'b0};
      SECTOR_1: pix_next = '{red: vx, green: vc, blue: vm, bad: 1'b0};
      SECTOR_2: pix_next = '{red: vm, green: vc, blue: vx, bad: 1'b0};
      SECTOR_3: pix_next = '{red: vm, green: vx, blue: vc, bad: 1'b0};
      SECTOR_4: pix_next = '{red: vx, green: vm, blue: vc, bad: 1'b0};
      default:  pix_next = '{red: vc, green: vm, blue: vx, bad: 1'b0};
    endcase
    if (s3_bad) begin
      pix_next = '{red: 8'd0, green: 8'd0, blue: 8'd0, bad: 1'b1};
    end
  end

  // Valid bits move with their words; reset empties every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  // Pipeline data registers.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_light <= light_next;
      s1_sat <= in_ratio.sat;
      s1_omd <= omd_next;
      s1_omf <= omf_next;
      s1_sector <= hs[FRAC_BITS+2:FRAC_BITS];
      s1_bad <= in_ratio.bad;
    end
    if (rdy[1]) begin
      s2_light <= s1_light;
      s2_omf <= s1_omf;
      s2_chroma <= chroma_next;
      s2_sector <= s1_sector;
      s2_bad <= s1_bad;
    end
    if (rdy[2]) begin
      s3_vc <= (QW+1)'(s2_chroma) + (QW+1)'(m_next);
      s3_vx <= (QW+1)'(x_next) + (QW+1)'(m_next);
      s3_m <= (QW+1)'(m_next);
      s3_sector <= s2_sector;
      s3_bad <= s2_bad;
    end
    if (rdy[3]) begin
      s4_pix <= pix_next;
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[3];
  assign out_pixel = s4_pix;

endmodule

// File: design/hue_lightness_map_pixel.sv
// Top level of the hue-lightness map pixel converter.
// An accepted word passes 17 divider stages, then 4 color stages, to its
// result word; throughput one pixel per clock while the output is not stalled.
// Every stage holds its word under backpressure and takes a new one once free.
// Synchronous active-high reset empties the pipeline and restores the
// registers to width 256, height 256, step 255, levels 256.
`include "hue_lightness_map_pixel_defines.svh"
module hue_lightness_map_pixel (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // col [11:0], row [23:12]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic m_tuser,          // range_error
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [hlm_pkg::CFG_W-1:0] cfg_data
);
  import hlm_pkg::*;

  logic [12:0] map_width, map_height;
  logic [7:0] sat_step;
  logic [8:0] sat_levels;
  logic [11:0] col, row;
  logic [12:0] height_m1;
  logic [8:0] levels_m1;
  logic bad;
  logic r_valid, r_ready;
  ratio_t ratio;
  pixel_t pix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 13'd256;
      map_height <= 13'd256;
      sat_step <= 8'd255;
      sat_levels <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH: map_width <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        REG_SAT_STEP: sat_step <= cfg_data[7:0];
        REG_SAT_LEVELS: sat_levels <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Range check of registers and coordinates.
  assign col = s_tdata[11:0];
  assign row = s_tdata[23:12];
  assign height_m1 = map_height - 13'd1;
  assign levels_m1 = sat_levels - 9'd1;
  assign bad = (map_width == 13'd0) || (map_width > 13'd4096) ||
               (map_height < 13'd2) || (map_height > 13'd4096) ||
               (sat_levels < 9'd2) || (sat_levels > 9'd256) ||
               (9'(sat_step) > levels_m1) ||
               (13'(col) >= map_width) || (13'(row) >= map_height);

  hlm_ratio u_ratio (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .col(col), .row(row), .step(sat_step), .bad(bad),
    .div_w(map_width), .div_h(height_m1), .div_l(CFG_W'(levels_m1)),
    .out_valid(r_valid), .out_ready(r_ready), .out_ratio(ratio)
  );

  hlm_color u_color (
    .clk(clk), .rst(rst),
    .in_valid(r_valid), .in_ready(r_ready), .in_ratio(ratio),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_pixel(pix)
  );

  assign m_tdata = {pix.blue, pix.green, pix.red};
  assign m_tuser = pix.bad;

  // An out-of-range pixel is black.
  `HLM_ASSERT_NOW(a_bad_black, m_tvalid && m_tuser, m_tdata == 24'd0, "error pixel not black")
  // An empty output stage means the whole pipeline can take a word.
  `HLM_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input stalled with empty output")
  // A good lightness quotient never exceeds one.
  `HLM_ASSERT_NOW(a_lq_range, r_valid && !ratio.bad, ratio.lq <= FX_ONE, "lightness ratio above one")
  // A stalled result stays in place unchanged.
  `HLM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule
